// File: hw/rtl/assert_macros.svh
// assertion helpers, clocked and disabled while in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/arvs_pkg.sv
package arvs_pkg;

  localparam int FUNC_W      = 3;
  localparam int DELTA_W     = 10;
  localparam int SET_W       = 16;
  localparam int STEP_W      = 16;
  localparam int MAXS_W      = 16;
  localparam int CFG_TIME_W  = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int MAX_RESULTS  = 52;
  localparam int CNT_W        = 6;
  localparam int MIN_INTERVAL = 20;

  localparam logic [MAXS_W-1:0]     MAX_STEPS_RST = 16'd100;
  localparam logic [CFG_TIME_W-1:0] DELAY_RST     = 12'd450;
  localparam logic [CFG_TIME_W-1:0] INTERVAL_RST  = 12'd120;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PRESS_LEFT  = 3'd0,
    FUNC_PRESS_RIGHT = 3'd1,
    FUNC_RELEASE     = 3'd2,
    FUNC_TICK        = 3'd3,
    FUNC_FOCUS_LOST  = 3'd4,
    FUNC_SET_INDEX   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_LEFT  = 2'd1,
    HOLD_RIGHT = 2'd2
  } hold_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_STEPS       = 2'd0,
    CFG_INITIAL_DELAY   = 2'd1,
    CFG_REPEAT_INTERVAL = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic press;
    logic disarm;
    logic set_idx;
    logic sub_delta;
    logic repeat_step;
    logic flush;
  } arvs_cmd_t;

  typedef struct packed {
    func_t func;
    logic  held;
    logic  ttr_le0;
    logic  will_change;
    logic  cap_ok;
    logic  pend_valid;
    logic  out_free;
  } arvs_sts_t;

endpackage

// File: hw/rtl/arvs_in_if.sv
interface arvs_in_if import arvs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [DELTA_W-1:0] delta_ms;
  logic [SET_W-1:0]   set_index;

  modport source (output valid, output func, output delta_ms, output set_index, input ready);
  modport sink (input valid, input func, input delta_ms, input set_index, output ready);
endinterface

// File: hw/rtl/arvs_out_if.sv
interface arvs_out_if import arvs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_index;
  logic              step_up;
  logic              last;

  modport source (output valid, output step_index, output step_up, output last, input ready);
  modport sink (input valid, input step_index, input step_up, input last, output ready);
endinterface

// File: hw/rtl/arvs_ctrl.sv
module arvs_ctrl import arvs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  arvs_sts_t sts,
  output arvs_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOOP,
    S_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   repeat_blocked;

  assign in_ready = (state_r == S_IDLE);

  // a changing step would push the pending item into a full output register
  assign repeat_blocked = sts.cap_ok && sts.will_change && sts.pend_valid && !sts.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.func)
          FUNC_PRESS_LEFT, FUNC_PRESS_RIGHT: begin
            cmd.press = 1'b1;
            state_nxt = S_FLUSH;
          end
          FUNC_RELEASE, FUNC_FOCUS_LOST: begin
            cmd.disarm = 1'b1;
            state_nxt  = S_IDLE;
          end
          FUNC_TICK: begin
            if (sts.held) begin
              cmd.sub_delta = 1'b1;
              state_nxt     = S_LOOP;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          FUNC_SET_INDEX: begin
            cmd.set_idx = 1'b1;
            state_nxt   = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_LOOP: begin
        if (!sts.ttr_le0) begin
          state_nxt = S_FLUSH;
        end else if (!repeat_blocked) begin
          cmd.repeat_step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/arvs_dp.sv
module arvs_dp import arvs_pkg::*; #(
  parameter int INDEX_BITS = 16,
  parameter int TIME_BITS  = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [DELTA_W-1:0]    in_delta_ms,
  input  logic [SET_W-1:0]      in_set_index,
  input  arvs_cmd_t             cmd,
  output arvs_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STEP_W-1:0]     out_step_index,
  output logic                  out_step_up,
  output logic                  out_last
);

  localparam int TTR_W = ((TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W) + 2;
  localparam int CMP_W = (INDEX_BITS > MAXS_W) ? INDEX_BITS : MAXS_W;
  localparam logic [CFG_TIME_W-1:0] TMASK = (TIME_BITS >= CFG_TIME_W) ?
    {CFG_TIME_W{1'b1}} : CFG_TIME_W'((1 << TIME_BITS) - 1);

  logic [MAXS_W-1:0]       max_steps_r;
  logic [CFG_TIME_W-1:0]   delay_r;
  logic [CFG_TIME_W-1:0]   interval_r;
  logic [INDEX_BITS-1:0]   step_idx_r;
  hold_t                   hold_r;
  logic signed [TTR_W-1:0] ttr_r;
  func_t                   func_r;
  logic [DELTA_W-1:0]      delta_r;
  logic [SET_W-1:0]        set_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    pend_valid_r;
  logic [INDEX_BITS-1:0]   pend_idx_r;
  logic                    pend_up_r;
  logic                    out_valid_r;
  logic [STEP_W-1:0]       out_idx_r;
  logic                    out_up_r;
  logic                    out_last_r;

  logic [CMP_W-1:0]        max_ext;
  logic [INDEX_BITS-1:0]   top;
  logic                    step_left;
  logic [INDEX_BITS:0]     inc;
  logic [INDEX_BITS-1:0]   dec;
  logic [INDEX_BITS:0]     raw;
  logic [INDEX_BITS-1:0]   nv;
  logic                    change;
  logic                    up;
  logic [CMP_W-1:0]        set_ext;
  logic [CMP_W-1:0]        top_ext;
  logic [INDEX_BITS-1:0]   set_clamped;
  logic [CFG_TIME_W-1:0]   iv;
  logic                    out_free;
  logic                    out_load;

  assign max_ext = CMP_W'(max_steps_r);
  assign top     = max_ext[INDEX_BITS-1:0];

  assign step_left = (func_r == FUNC_TICK) ? (hold_r == HOLD_LEFT) :
                                             (func_r == FUNC_PRESS_LEFT);
  assign inc    = {1'b0, step_idx_r} + (INDEX_BITS+1)'(1);
  assign dec    = (step_idx_r == '0) ? '0 : step_idx_r - INDEX_BITS'(1);
  assign raw    = step_left ? {1'b0, dec} : inc;
  assign nv     = (raw > {1'b0, top}) ? top : raw[INDEX_BITS-1:0];
  assign change = (nv != step_idx_r);
  assign up     = (nv > step_idx_r);

  assign set_ext     = CMP_W'(set_r);
  assign top_ext     = CMP_W'(top);
  assign set_clamped = (set_ext > top_ext) ? top : set_ext[INDEX_BITS-1:0];

  assign iv       = (interval_r < CFG_TIME_W'(MIN_INTERVAL)) ?
                    CFG_TIME_W'(MIN_INTERVAL) : interval_r;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = cmd.flush || (cmd.repeat_step && sts.cap_ok && change && pend_valid_r);

  assign sts.func        = func_r;
  assign sts.held        = (hold_r != HOLD_NONE);
  assign sts.ttr_le0     = ttr_r[TTR_W-1] || (ttr_r == '0);
  assign sts.will_change = change;
  assign sts.cap_ok      = (cnt_r < CNT_W'(MAX_RESULTS));
  assign sts.pend_valid  = pend_valid_r;
  assign sts.out_free    = out_free;

  assign out_valid      = out_valid_r;
  assign out_step_index = out_idx_r;
  assign out_step_up    = out_up_r;
  assign out_last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= MAX_STEPS_RST;
      delay_r     <= DELAY_RST & TMASK;
      interval_r  <= INTERVAL_RST & TMASK;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_STEPS:       max_steps_r <= cfg_data[MAXS_W-1:0];
        CFG_INITIAL_DELAY:   delay_r     <= cfg_data[CFG_TIME_W-1:0] & TMASK;
        CFG_REPEAT_INTERVAL: interval_r  <= cfg_data[CFG_TIME_W-1:0] & TMASK;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_idx_r   <= '0;
      hold_r       <= HOLD_NONE;
      ttr_r        <= '0;
      func_r       <= FUNC_RELEASE;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        func_r  <= func_t'(in_func);
        delta_r <= in_delta_ms;
        set_r   <= in_set_index;
        cnt_r   <= '0;
      end
      if (cmd.press) begin
        if (change) begin
          step_idx_r   <= nv;
          pend_valid_r <= 1'b1;
          pend_idx_r   <= nv;
          pend_up_r    <= up;
        end
        hold_r <= step_left ? HOLD_LEFT : HOLD_RIGHT;
        ttr_r  <= $signed(TTR_W'(delay_r));
      end
      if (cmd.disarm) begin
        hold_r <= HOLD_NONE;
      end
      if (cmd.set_idx) begin
        step_idx_r <= set_clamped;
      end
      if (cmd.sub_delta) begin
        ttr_r <= ttr_r - $signed(TTR_W'(delta_r));
      end
      if (cmd.repeat_step) begin
        ttr_r <= ttr_r + $signed(TTR_W'(iv));
        if (sts.cap_ok && change) begin
          step_idx_r   <= nv;
          pend_valid_r <= 1'b1;
          pend_idx_r   <= nv;
          pend_up_r    <= up;
          cnt_r        <= cnt_r + CNT_W'(1);
          // previous pending item is not the last one
          if (pend_valid_r) begin
            out_idx_r   <= STEP_W'(pend_idx_r);
            out_up_r    <= pend_up_r;
            out_last_r  <= 1'b0;
          end
        end
      end
      if (cmd.flush) begin
        pend_valid_r <= 1'b0;
        out_idx_r    <= STEP_W'(pend_idx_r);
        out_up_r     <= pend_up_r;
        out_last_r   <= 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/auto_repeat_value_stepper.sv
// channel   dir   handshake      payload
// in_if     in    valid/ready    func, delta_ms, set_index
// out_if    out   valid/ready    step_index, step_up, last
// cfg_*     in    cfg_we         cfg_index, cfg_data
//
// set, release, focus loss, unused codes and a tick while not held pass through IDLE and EXEC
// a press goes on to FLUSH; a held tick goes through LOOP, which consumes the repeat intervals, then FLUSH
// the step loop runs one step a cycle, when not stalled, through a single compare-and-clamp unit
// a held output item stalls the loop only when a further changing step is due
// the final item of an input waits until the output register is free
// synchronous reset, no clearing pass
`include "assert_macros.svh"

module auto_repeat_value_stepper import arvs_pkg::*; #(
  parameter int INDEX_BITS = 16,
  parameter int TIME_BITS  = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  arvs_in_if.sink               in_if,
  arvs_out_if.source            out_if
);

  arvs_cmd_t                     cmd;
  arvs_sts_t                     sts;
  logic [$bits(arvs_cmd_t)-1:0]  cmd_bits;
  logic                          in_take;

  assign cmd_bits = cmd;
  assign in_take  = in_if.valid && in_if.ready;

  arvs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arvs_dp #(
    .INDEX_BITS (INDEX_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_func        (in_if.func),
    .in_delta_ms    (in_if.delta_ms),
    .in_set_index   (in_if.set_index),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_step_index (out_if.step_index),
    .out_step_up    (out_if.step_up),
    .out_last       (out_if.last)
  );

  `ASSERT_RST(a_cmd_onehot, clk, rst_n, $onehot0(cmd_bits), "more than one command")
  `ASSERT_RST(a_accept_clean, clk, rst_n, in_take |-> !sts.pend_valid, "result still pending")
  `ASSERT_RST(a_repeat_due, clk, rst_n, cmd.repeat_step |-> sts.ttr_le0, "early repeat step")
  `ASSERT_RST(a_flush_free, clk, rst_n, cmd.flush |-> sts.out_free, "flush into a busy output")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_take, !in_if.ready, "ready after accept")

endmodule

// File: verif/testbench.sv
module testbench;
  import arvs_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  localparam int CHK_MODEL = -1;
  localparam int CHK_NONE  = 0;
  localparam int CHK_ONE   = 1;

  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 26;
  localparam int TIMEOUT_UNITS = 3_000_000;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [DELTA_W-1:0] delta;
    logic [SET_W-1:0]   setv;
  } stim_t;

  typedef struct packed {
    logic [STEP_W-1:0] idx;
    logic              up;
    logic              last;
  } step_res_t;

  typedef struct {
    bit                wr;
    cfg_idx_t          sel;
    logic [15:0]       val;
    stim_t             it;
    int                chk;
    logic [STEP_W-1:0] t_idx;
    logic              t_up;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  arvs_in_if  in_if ();
  arvs_out_if out_if ();

  auto_repeat_value_stepper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  // predictor state and register copies
  logic [MAXS_W-1:0]     cfg_max;
  logic [CFG_TIME_W-1:0] cfg_delay;
  logic [CFG_TIME_W-1:0] cfg_iv;
  logic [STEP_W-1:0]     cur_idx;
  hold_t                 hold;
  int                    ttr;

  step_res_t step_due [$];
  step_res_t new_steps [$];
  plan_row_t plan [$];

  bit calm;
  int errors;
  int items_sent;
  int steps_seen;
  int max_burst;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("Verification failed");
    $finish;
  end

  function automatic bit try_step(hold_t dir, output step_res_t r);
    logic [STEP_W:0] top;
    logic [STEP_W:0] old;
    logic [STEP_W:0] nv;
    top = {1'b0, cfg_max};
    old = {1'b0, cur_idx};
    if (dir == HOLD_LEFT) begin
      nv = (old == '0) ? '0 : old - 1'b1;
    end else begin
      nv = old + 1'b1;
    end
    if (nv > top) nv = top;
    r = '0;
    if (nv == old) return 1'b0;
    cur_idx = nv[STEP_W-1:0];
    r.idx = nv[STEP_W-1:0];
    r.up = (nv > old);
    r.last = 1'b0;
    return 1'b1;
  endfunction

  function automatic void apply_item(stim_t s);
    step_res_t r;
    hold_t dir;
    int iv;
    new_steps.delete();
    case (s.func)
      FUNC_PRESS_LEFT, FUNC_PRESS_RIGHT: begin
        dir = (s.func == FUNC_PRESS_LEFT) ? HOLD_LEFT : HOLD_RIGHT;
        if (try_step(dir, r)) new_steps = {new_steps, r};
        hold = dir;
        ttr = int'(cfg_delay);
      end
      FUNC_RELEASE, FUNC_FOCUS_LOST: begin
        hold = HOLD_NONE;
      end
      FUNC_TICK: begin
        if (hold != HOLD_NONE) begin
          iv = int'(cfg_iv);
          if (iv < MIN_INTERVAL) iv = MIN_INTERVAL;
          ttr = ttr - int'(s.delta);
          while (ttr <= 0) begin
            if (new_steps.size() < MAX_RESULTS && try_step(hold, r)) new_steps = {new_steps, r};
            ttr = ttr + iv;
          end
        end
      end
      FUNC_SET_INDEX: begin
        cur_idx = (s.setv > cfg_max) ? cfg_max : s.setv;
      end
      default: begin
      end
    endcase
    if (new_steps.size() > 0) begin
      new_steps[new_steps.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    step_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      steps_seen++;
      if (step_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected step item, expected none, got index %0d up %0b last %0b",
                 $time, out_if.step_index, out_if.step_up, out_if.last);
      end else begin
        want = step_due.pop_front();
        check_field("step_index", int'(want.idx), int'(out_if.step_index));
        check_field("step_up", int'(want.up), int'(out_if.step_up));
        check_field("last", int'(want.last), int'(out_if.last));
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
    end
  end

  task automatic put_item(stim_t s, int chk, logic [STEP_W-1:0] t_idx, logic t_up);
    int gap;
    step_res_t r;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= s.func;
    in_if.delta_ms  <= s.delta;
    in_if.set_index <= s.setv;
    do @(posedge clk); while (!in_if.ready);
    apply_item(s);
    if (chk == CHK_MODEL) begin
      if (new_steps.size() > max_burst) max_burst = new_steps.size();
      foreach (new_steps[k]) step_due = {step_due, new_steps[k]};
    end else if (chk == CHK_ONE) begin
      r.idx = t_idx;
      r.up = t_up;
      r.last = 1'b1;
      step_due = {step_due, r};
    end
    if (s.func != FUNC_SPARE_6 && s.func != FUNC_SPARE_7) items_sent++;
    @(negedge clk);
  endtask

  // stop sending, let every expected step arrive and the tick loop finish
  task automatic settle();
    in_if.valid <= 1'b0;
    while (step_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t sel, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= v;
    case (sel)
      CFG_MAX_STEPS:       cfg_max = v;
      CFG_INITIAL_DELAY:   cfg_delay = v[CFG_TIME_W-1:0];
      CFG_REPEAT_INTERVAL: cfg_iv = v[CFG_TIME_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [DELTA_W-1:0] pick_delta();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return r[DELTA_W-1:0];
      default: return {3'b000, r[6:0]};
    endcase
  endfunction

  function automatic logic [SET_W-1:0] pick_index();
    logic [31:0] r;
    int v;
    r = $urandom;
    v = $urandom_range(0, int'(cfg_max) + 2);
    if (v > 65535) v = 65535;
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return r[SET_W-1:0];
      default: return v[SET_W-1:0];
    endcase
  endfunction

  task automatic send_op(logic [FUNC_W-1:0] f);
    stim_t s;
    s.func = f;
    s.delta = pick_delta();
    s.setv = pick_index();
    put_item(s, CHK_MODEL, '0, 1'b0);
  endtask

  function automatic plan_row_t op_row(logic [FUNC_W-1:0] f, logic [DELTA_W-1:0] d,
                                       logic [SET_W-1:0] sv, int chk,
                                       logic [STEP_W-1:0] ti, logic tu);
    plan_row_t row;
    row.wr = 1'b0;
    row.sel = CFG_MAX_STEPS;
    row.val = '0;
    row.it.func = f;
    row.it.delta = d;
    row.it.setv = sv;
    row.chk = chk;
    row.t_idx = ti;
    row.t_up = tu;
    return row;
  endfunction

  function automatic plan_row_t reg_row(cfg_idx_t sel, logic [15:0] v);
    plan_row_t row;
    row = op_row(FUNC_RELEASE, '0, '0, CHK_NONE, '0, 1'b0);
    row.wr = 1'b1;
    row.sel = sel;
    row.val = v;
    return row;
  endfunction

  function automatic void add_row(plan_row_t row);
    plan = {plan, row};
  endfunction

  initial begin : stimulus
    logic [31:0] r;
    int p;
    int k;
    int ticks;
    int target;
    int mx;
    int dl;
    int ivc;
    bit paused;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.func = '0;
    in_if.delta_ms = '0;
    in_if.set_index = '0;
    calm = 1'b0;
    paused = 1'b0;
    errors = 0;
    items_sent = 0;
    steps_seen = 0;
    max_burst = 0;
    cfg_max = MAX_STEPS_RST;
    cfg_delay = DELAY_RST;
    cfg_iv = INTERVAL_RST;
    cur_idx = '0;
    hold = HOLD_NONE;
    ttr = 0;

    add_row(op_row(FUNC_TICK,        10'd1023, 16'd0,     CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_RELEASE,     10'd0,    16'd0,     CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_PRESS_LEFT,  10'd0,    16'd0,     CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_TICK,        10'd1023, 16'd0,     CHK_MODEL, 16'd0,  1'b0));
    add_row(op_row(FUNC_FOCUS_LOST,  10'd0,    16'd0,     CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_PRESS_RIGHT, 10'd0,    16'd0,     CHK_ONE,   16'd1,  1'b1));
    add_row(op_row(FUNC_TICK,        10'd450,  16'd0,     CHK_MODEL, 16'd0,  1'b0));
    add_row(op_row(FUNC_TICK,        10'd1023, 16'd0,     CHK_MODEL, 16'd0,  1'b0));
    add_row(op_row(FUNC_PRESS_LEFT,  10'd0,    16'd0,     CHK_MODEL, 16'd0,  1'b0));
    add_row(op_row(FUNC_SET_INDEX,   10'd0,    16'hFFFF,  CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_PRESS_RIGHT, 10'd0,    16'd0,     CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_RELEASE,     10'd0,    16'd0,     CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_SPARE_6,     10'd0,    16'd0,     CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_SPARE_7,     10'd1023, 16'hFFFF,  CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_SET_INDEX,   10'd0,    16'd0,     CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_PRESS_RIGHT, 10'd0,    16'd0,     CHK_ONE,   16'd1,  1'b1));
    add_row(op_row(FUNC_PRESS_LEFT,  10'd0,    16'd0,     CHK_ONE,   16'd0,  1'b0));
    add_row(op_row(FUNC_TICK,        10'd0,    16'd0,     CHK_MODEL, 16'd0,  1'b0));
    add_row(op_row(FUNC_SET_INDEX,   10'd0,    16'd100,   CHK_NONE,  16'd0,  1'b0));
    // index left above a lowered ceiling
    add_row(reg_row(CFG_MAX_STEPS, 16'd10));
    add_row(op_row(FUNC_PRESS_RIGHT, 10'd0,    16'd0,     CHK_ONE,   16'd10, 1'b0));
    add_row(reg_row(CFG_MAX_STEPS, 16'hFFFF));
    add_row(reg_row(CFG_INITIAL_DELAY, 16'd0));
    add_row(reg_row(CFG_REPEAT_INTERVAL, 16'd0));
    add_row(op_row(FUNC_PRESS_RIGHT, 10'd0,    16'd0,     CHK_ONE,   16'd11, 1'b1));
    add_row(op_row(FUNC_TICK,        10'd1023, 16'd0,     CHK_MODEL, 16'd0,  1'b0));
    add_row(op_row(FUNC_TICK,        10'd1023, 16'd0,     CHK_MODEL, 16'd0,  1'b0));
    add_row(reg_row(CFG_REPEAT_INTERVAL, 16'd4095));
    add_row(reg_row(CFG_INITIAL_DELAY, 16'd4095));
    add_row(reg_row(CFG_MAX_STEPS, 16'd0));
    add_row(op_row(FUNC_SET_INDEX,   10'd0,    16'hFFFF,  CHK_NONE,  16'd0,  1'b0));
    add_row(op_row(FUNC_PRESS_RIGHT, 10'd0,    16'd0,     CHK_NONE,  16'd0,  1'b0));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].wr) begin
        settle();
        write_reg(plan[i].sel, plan[i].val);
      end else begin
        put_item(plan[i].it, plan[i].chk, plan[i].t_idx, plan[i].t_up);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      settle();
      calm = (p == 2 || p == 5);
      case (p)
        0: begin
          mx = $urandom_range(0, 200); dl = $urandom_range(0, 600); ivc = $urandom_range(20, 300);
        end
        1: begin
          mx = 65535; dl = 0; ivc = 20;
        end
        2: begin
          mx = 3; dl = 4095; ivc = 4095;
        end
        3: begin
          mx = $urandom_range(0, 65535); dl = $urandom_range(0, 600); ivc = $urandom_range(0, 19);
        end
        4: begin
          mx = 0; dl = $urandom_range(0, 300); ivc = $urandom_range(20, 200);
        end
        5: begin
          mx = 200; dl = 0; ivc = 19;
        end
        6: begin
          mx = $urandom_range(0, 65535); dl = $urandom_range(0, 4095);
          ivc = $urandom_range(20, 4095);
        end
        default: begin
          mx = 1; dl = $urandom_range(0, 100); ivc = 20;
        end
      endcase
      write_reg(CFG_MAX_STEPS, mx[15:0]);
      write_reg(CFG_INITIAL_DELAY, dl[15:0]);
      write_reg(CFG_REPEAT_INTERVAL, ivc[15:0]);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (p == 3 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 8) begin
          // press, hold with ticks, then usually let go
          send_op($urandom_range(0, 1) ? FUNC_PRESS_RIGHT : FUNC_PRESS_LEFT);
          ticks = $urandom_range(1, 6);
          for (k = 0; k < ticks; k++) begin
            case ($urandom_range(0, 11))
              0: send_op($urandom_range(0, 1) ? FUNC_PRESS_RIGHT : FUNC_PRESS_LEFT);
              1: send_op(FUNC_SET_INDEX);
              default: send_op(FUNC_TICK);
            endcase
          end
          if ($urandom_range(0, 9) != 0) begin
            send_op($urandom_range(0, 1) ? FUNC_RELEASE : FUNC_FOCUS_LOST);
          end
        end else begin
          r = $urandom;
          send_op(r[FUNC_W-1:0]);
        end
      end
    end

    settle();
    $display("%0d items over %0d register settings, %0d step items checked",
             items_sent, PHASES + 1, steps_seen);
    $display("longest burst from one tick: %0d steps", max_burst);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
